>>> src/tod_pkg.sv
// Shared types and constants for the time-of-day counter.
`default_nettype none

package tod_pkg;

    // Step commands carried by each input transaction
    typedef enum logic [3:0] {
        OP_QUERY        = 4'd0,
        OP_ADD_SEC      = 4'd1,
        OP_ADD_MIN      = 4'd2,
        OP_ADD_MIN_ONLY = 4'd3,
        OP_ADD_HOUR     = 4'd4,
        OP_SUB_SEC      = 4'd5,
        OP_SUB_MIN      = 4'd6,
        OP_SUB_MIN_ONLY = 4'd7,
        OP_SUB_HOUR     = 4'd8,
        OP_SET          = 4'd9
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TARGET_HOURS   = 2'd0,
        CFG_TARGET_MINUTES = 2'd1,
        CFG_TARGET_SECONDS = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_time;

    // Formatted view of one time value
    typedef struct packed {
        logic [1:0]  hours_tens;
        logic [3:0]  hours_units;
        logic [2:0]  minutes_tens;
        logic [3:0]  minutes_units;
        logic [2:0]  seconds_tens;
        logic [3:0]  seconds_units;
        logic [16:0] day_seconds;
        logic        matches_target;
        logic        last_second_of_day;
    } t_fmt;

    localparam logic [4:0] LAST_HOUR   = 5'd23;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [5:0] LAST_SECOND = 6'd59;
    localparam logic [7:0] HOURS_DAY   = 8'd24;
    localparam logic [7:0] MINUTES_HR  = 8'd60;
    localparam logic [16:0] SEC_PER_HR  = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN = 17'd60;
    localparam logic [5:0] DECADE      = 6'd10;

    localparam t_time RESET_TIME = '{hours: 5'd23, minutes: 6'd59, seconds: 6'd40};

endpackage

`default_nettype wire

>>> src/tod_step.sv
// Next-time logic: applies one step command to the current time.
`default_nettype none

module tod_step (
    input  wire tod_pkg::t_time cur,
    input  wire logic [3:0]     opcode,
    input  wire logic [7:0]     set_hours,
    input  wire logic [7:0]     set_minutes,
    input  wire logic [7:0]     set_seconds,
    output tod_pkg::t_time      nxt
);
    import tod_pkg::*;

    logic [4:0] hour_inc, hour_dec;
    logic [5:0] min_inc, min_dec, sec_inc, sec_dec;
    logic       min_wrap_up, min_wrap_dn, sec_wrap_up, sec_wrap_dn;

    // Wraparound neighbors of each field
    always_comb begin
        hour_inc    = (cur.hours >= LAST_HOUR) ? 5'd0 : cur.hours + 5'd1;
        hour_dec    = (cur.hours == 5'd0) ? LAST_HOUR : cur.hours - 5'd1;
        min_wrap_up = (cur.minutes >= LAST_MINUTE);
        min_wrap_dn = (cur.minutes == 6'd0);
        min_inc     = min_wrap_up ? 6'd0 : cur.minutes + 6'd1;
        min_dec     = min_wrap_dn ? LAST_MINUTE : cur.minutes - 6'd1;
        sec_wrap_up = (cur.seconds >= LAST_SECOND);
        sec_wrap_dn = (cur.seconds == 6'd0);
        sec_inc     = sec_wrap_up ? 6'd0 : cur.seconds + 6'd1;
        sec_dec     = sec_wrap_dn ? LAST_SECOND : cur.seconds - 6'd1;
    end

    // Select the stepped time; unused codes hold the time
    always_comb begin
        nxt = cur;
        unique case (t_opcode'(opcode))
            OP_ADD_SEC: begin
                nxt.seconds = sec_inc;
                if (sec_wrap_up) begin
                    nxt.minutes = min_inc;
                    if (min_wrap_up) nxt.hours = hour_inc;
                end
            end
            OP_ADD_MIN: begin
                nxt.minutes = min_inc;
                if (min_wrap_up) nxt.hours = hour_inc;
            end
            OP_ADD_MIN_ONLY: nxt.minutes = min_inc;
            OP_ADD_HOUR:     nxt.hours   = hour_inc;
            OP_SUB_SEC: begin
                nxt.seconds = sec_dec;
                if (sec_wrap_dn) begin
                    nxt.minutes = min_dec;
                    if (min_wrap_dn) nxt.hours = hour_dec;
                end
            end
            OP_SUB_MIN: begin
                nxt.minutes = min_dec;
                if (min_wrap_dn) nxt.hours = hour_dec;
            end
            OP_SUB_MIN_ONLY: nxt.minutes = min_dec;
            OP_SUB_HOUR:     nxt.hours   = hour_dec;
            OP_SET: begin
                nxt.hours   = (set_hours   < HOURS_DAY)  ? set_hours[4:0]   : 5'd0;
                nxt.minutes = (set_minutes < MINUTES_HR) ? set_minutes[5:0] : 6'd0;
                nxt.seconds = (set_seconds < MINUTES_HR) ? set_seconds[5:0] : 6'd0;
            end
            default: nxt = cur;
        endcase
    end

endmodule

`default_nettype wire

>>> src/tod_fmt.sv
// Formatting logic: decimal digits, seconds of day and compare flags.
`default_nettype none

module tod_fmt (
    input  wire tod_pkg::t_time tm,
    input  wire tod_pkg::t_time target,
    output tod_pkg::t_fmt       fmt
);
    import tod_pkg::*;

    // Tens digit of a value below 64 by comparison ladder
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if      (v >= 6'd60) t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    logic [2:0] h_t, m_t, s_t;
    logic [5:0] h_u, m_u, s_u;

    // Split each field into decimal digits
    always_comb begin
        h_t = tens_of({1'b0, tm.hours});
        m_t = tens_of(tm.minutes);
        s_t = tens_of(tm.seconds);
        h_u = {1'b0, tm.hours} - 6'({3'd0, h_t} * DECADE);
        m_u = tm.minutes - 6'({3'd0, m_t} * DECADE);
        s_u = tm.seconds - 6'({3'd0, s_t} * DECADE);
    end

    // Assemble the formatted result
    always_comb begin
        fmt.hours_tens    = h_t[1:0];
        fmt.hours_units   = h_u[3:0];
        fmt.minutes_tens  = m_t;
        fmt.minutes_units = m_u[3:0];
        fmt.seconds_tens  = s_t;
        fmt.seconds_units = s_u[3:0];
        fmt.day_seconds   = 17'(17'(tm.hours) * SEC_PER_HR)
                          + 17'(17'(tm.minutes) * SEC_PER_MIN)
                          + 17'(tm.seconds);
        fmt.matches_target     = (tm == target);
        fmt.last_second_of_day = (tm.hours == LAST_HOUR) && (tm.minutes == LAST_MINUTE)
                               && (tm.seconds == LAST_SECOND);
    end

endmodule

`default_nettype wire

>>> src/time_of_day_counter.sv
// Top level of the 24-hour time-of-day counter with its result register.
// An accepted input transaction's result is registered and shows on o_valid in the next cycle.
// Throughput: one transaction per cycle while o_stall is low; the step, digit split
// and seconds-of-day product all fit between the time register and the output register.
// Reset (synchronous, active low): time 23:59:40, targets 00:00:00, no result held.
// o_stall rises only while a result is held and the downstream side stalls.
`default_nettype none

module time_of_day_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [7:0]  i_set_hours,
    input  wire logic [7:0]  i_set_minutes,
    input  wire logic [7:0]  i_set_seconds,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_hours_now,
    output logic [5:0]       o_minutes_now,
    output logic [5:0]       o_seconds_now,
    output logic [1:0]       o_hours_tens,
    output logic [3:0]       o_hours_units,
    output logic [2:0]       o_minutes_tens,
    output logic [3:0]       o_minutes_units,
    output logic [2:0]       o_seconds_tens,
    output logic [3:0]       o_seconds_units,
    output logic [16:0]      o_day_seconds,
    output logic             o_matches_target,
    output logic             o_last_second_of_day,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [5:0]  i_cfg_data
);
    import tod_pkg::*;

    t_time r_time, n_time;
    t_time r_target;
    t_time r_out_time;
    t_fmt  r_out_fmt, n_fmt;
    logic  r_out_valid;
    logic  in_accept, out_take;

    // Handshake
    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid & i_stall;
    assign in_accept   = i_valid & ~o_stall;
    assign out_take    = r_out_valid & ~i_stall;

    tod_step u_step (
        .cur         (r_time),
        .opcode      (i_opcode),
        .set_hours   (i_set_hours),
        .set_minutes (i_set_minutes),
        .set_seconds (i_set_seconds),
        .nxt         (n_time)
    );

    tod_fmt u_fmt (
        .tm     (n_time),
        .target (r_target),
        .fmt    (n_fmt)
    );

    // Advance the time on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= RESET_TIME;
        end else if (in_accept) begin
            r_time <= n_time;
        end
    end

    // Target registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TARGET_HOURS:   r_target.hours   <= i_cfg_data[4:0];
                CFG_TARGET_MINUTES: r_target.minutes <= i_cfg_data;
                CFG_TARGET_SECONDS: r_target.seconds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_time <= n_time;
            r_out_fmt  <= n_fmt;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_hours_now          = r_out_time.hours;
    assign o_minutes_now        = r_out_time.minutes;
    assign o_seconds_now        = r_out_time.seconds;
    assign o_hours_tens         = r_out_fmt.hours_tens;
    assign o_hours_units        = r_out_fmt.hours_units;
    assign o_minutes_tens       = r_out_fmt.minutes_tens;
    assign o_minutes_units      = r_out_fmt.minutes_units;
    assign o_seconds_tens       = r_out_fmt.seconds_tens;
    assign o_seconds_units      = r_out_fmt.seconds_units;
    assign o_day_seconds        = r_out_fmt.day_seconds;
    assign o_matches_target     = r_out_fmt.matches_target;
    assign o_last_second_of_day = r_out_fmt.last_second_of_day;

    // Checks
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("input stalled with no result held");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time.hours <= LAST_HOUR && r_time.minutes <= LAST_MINUTE
        && r_time.seconds <= LAST_SECOND)
        else $error("time state out of range");

    a_day_seconds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_fmt.day_seconds < 17'd86400))
        else $error("seconds of day out of range");

    a_last_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fmt.last_second_of_day) |-> (r_out_fmt.day_seconds == 17'd86399))
        else $error("last-second flag disagrees with seconds of day");

endmodule

`default_nettype wire

>>> tb/tb_time_of_day_counter.sv
// Self-checking testbench for the 24-hour time-of-day counter.
`timescale 1ns / 1ps

module tb_time_of_day_counter;
    import tod_pkg::*;

    // Opcodes with no step of their own behave as a query
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct {
        logic [3:0] opcode;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } t_clock_step;

    typedef struct {
        t_time now;
        t_fmt  fmt;
    } t_clock_view;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_opcode = OP_QUERY;
    logic [7:0]  i_set_hours = '0;
    logic [7:0]  i_set_minutes = '0;
    logic [7:0]  i_set_seconds = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_hours_now;
    logic [5:0]  o_minutes_now;
    logic [5:0]  o_seconds_now;
    logic [1:0]  o_hours_tens;
    logic [3:0]  o_hours_units;
    logic [2:0]  o_minutes_tens;
    logic [3:0]  o_minutes_units;
    logic [2:0]  o_seconds_tens;
    logic [3:0]  o_seconds_units;
    logic [16:0] o_day_seconds;
    logic        o_matches_target;
    logic        o_last_second_of_day;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_TARGET_HOURS;
    logic [5:0]  i_cfg_data = '0;

    // Predicted clock and target registers
    logic [4:0] clk_h = RESET_TIME.hours;
    logic [5:0] clk_m = RESET_TIME.minutes;
    logic [5:0] clk_s = RESET_TIME.seconds;
    logic [4:0] tgt_h = '0;
    logic [5:0] tgt_m = '0;
    logic [5:0] tgt_s = '0;

    t_clock_step pending_steps[$];
    t_clock_view expected_times[$];
    t_clock_step cur_step;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic rx_hold = 1'b0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int accepted_steps = 0;
    int checked_results = 0;
    int target_hits = 0;
    int last_second_hits = 0;

    time_of_day_counter i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_opcode             (i_opcode),
        .i_set_hours          (i_set_hours),
        .i_set_minutes        (i_set_minutes),
        .i_set_seconds        (i_set_seconds),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_hours_now          (o_hours_now),
        .o_minutes_now        (o_minutes_now),
        .o_seconds_now        (o_seconds_now),
        .o_hours_tens         (o_hours_tens),
        .o_hours_units        (o_hours_units),
        .o_minutes_tens       (o_minutes_tens),
        .o_minutes_units      (o_minutes_units),
        .o_seconds_tens       (o_seconds_tens),
        .o_seconds_units      (o_seconds_units),
        .o_day_seconds        (o_day_seconds),
        .o_matches_target     (o_matches_target),
        .o_last_second_of_day (o_last_second_of_day),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predicted wraparound steps
    function automatic void hour_fwd();
        clk_h = (clk_h >= LAST_HOUR) ? 5'd0 : clk_h + 5'd1;
    endfunction

    function automatic void hour_back();
        clk_h = (clk_h == 5'd0) ? LAST_HOUR : clk_h - 5'd1;
    endfunction

    function automatic void minute_fwd(logic carry);
        if (clk_m >= LAST_MINUTE) begin
            clk_m = 6'd0;
            if (carry)
                hour_fwd();
        end else begin
            clk_m = clk_m + 6'd1;
        end
    endfunction

    function automatic void minute_back(logic borrow);
        if (clk_m == 6'd0) begin
            clk_m = LAST_MINUTE;
            if (borrow)
                hour_back();
        end else begin
            clk_m = clk_m - 6'd1;
        end
    endfunction

    // Apply one step to the predicted clock and return the time it shows
    function automatic t_clock_view step_clock(t_clock_step st);
        t_clock_view r;
        case (st.opcode)
            OP_ADD_SEC: begin
                if (clk_s >= LAST_SECOND) begin
                    clk_s = 6'd0;
                    minute_fwd(1'b1);
                end else begin
                    clk_s = clk_s + 6'd1;
                end
            end
            OP_ADD_MIN:      minute_fwd(1'b1);
            OP_ADD_MIN_ONLY: minute_fwd(1'b0);
            OP_ADD_HOUR:     hour_fwd();
            OP_SUB_SEC: begin
                if (clk_s == 6'd0) begin
                    clk_s = LAST_SECOND;
                    minute_back(1'b1);
                end else begin
                    clk_s = clk_s - 6'd1;
                end
            end
            OP_SUB_MIN:      minute_back(1'b1);
            OP_SUB_MIN_ONLY: minute_back(1'b0);
            OP_SUB_HOUR:     hour_back();
            OP_SET: begin
                clk_h = (st.hours < HOURS_DAY) ? st.hours[4:0] : 5'd0;
                clk_m = (st.minutes < MINUTES_HR) ? st.minutes[5:0] : 6'd0;
                clk_s = (st.seconds < MINUTES_HR) ? st.seconds[5:0] : 6'd0;
            end
            default: ;
        endcase
        r.now.hours = clk_h;
        r.now.minutes = clk_m;
        r.now.seconds = clk_s;
        r.fmt.hours_tens = 2'(clk_h / DECADE);
        r.fmt.hours_units = 4'(clk_h % DECADE);
        r.fmt.minutes_tens = 3'(clk_m / DECADE);
        r.fmt.minutes_units = 4'(clk_m % DECADE);
        r.fmt.seconds_tens = 3'(clk_s / DECADE);
        r.fmt.seconds_units = 4'(clk_s % DECADE);
        r.fmt.day_seconds = 17'(17'(clk_h) * SEC_PER_HR + 17'(clk_m) * SEC_PER_MIN
                                + 17'(clk_s));
        r.fmt.matches_target = (clk_h == tgt_h) && (clk_m == tgt_m) && (clk_s == tgt_s);
        r.fmt.last_second_of_day = (clk_h == LAST_HOUR) && (clk_m == LAST_MINUTE) &&
                                   (clk_s == LAST_SECOND);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer queued steps; predict each transaction as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_times.push_back(step_clock(cur_step));
                accepted_steps++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_step = pending_steps.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= cur_step.opcode;
                    i_set_hours <= cur_step.hours;
                    i_set_minutes <= cur_step.minutes;
                    i_set_seconds <= cur_step.seconds;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel at random, or hold it off entirely
    always @(posedge i_clk) begin
        i_stall <= rx_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each accepted result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_clock_view want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_times.size() == 0) begin
                $error("result transaction with no step outstanding");
                mismatch_count++;
            end else begin
                want = expected_times.pop_front();
                check_field("hours_now", want.now.hours, o_hours_now);
                check_field("minutes_now", want.now.minutes, o_minutes_now);
                check_field("seconds_now", want.now.seconds, o_seconds_now);
                check_field("hours_tens", want.fmt.hours_tens, o_hours_tens);
                check_field("hours_units", want.fmt.hours_units, o_hours_units);
                check_field("minutes_tens", want.fmt.minutes_tens, o_minutes_tens);
                check_field("minutes_units", want.fmt.minutes_units, o_minutes_units);
                check_field("seconds_tens", want.fmt.seconds_tens, o_seconds_tens);
                check_field("seconds_units", want.fmt.seconds_units, o_seconds_units);
                check_field("day_seconds", want.fmt.day_seconds, o_day_seconds);
                check_field("matches_target", want.fmt.matches_target, o_matches_target);
                check_field("last_second_of_day", want.fmt.last_second_of_day,
                            o_last_second_of_day);
                checked_results++;
                if (want.fmt.matches_target)
                    target_hits++;
                if (want.fmt.last_second_of_day)
                    last_second_hits++;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_step(logic [3:0] op, logic [7:0] h, logic [7:0] m, logic [7:0] s);
        t_clock_step st;
        st.opcode = op;
        st.hours = h;
        st.minutes = m;
        st.seconds = s;
        pending_steps.push_back(st);
    endtask

    // Write one target register; the predictor follows once it is taken
    task automatic write_target(t_cfg_index idx, logic [5:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET_HOURS:   tgt_h = value[4:0];
            CFG_TARGET_MINUTES: tgt_m = value;
            CFG_TARGET_SECONDS: tgt_s = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_targets(logic [5:0] h, logic [5:0] m, logic [5:0] s);
        write_target(CFG_TARGET_HOURS, h);
        write_target(CFG_TARGET_MINUTES, m);
        write_target(CFG_TARGET_SECONDS, s);
    endtask

    // Block until every queued step has been taken and answered
    task automatic wait_idle();
        while (pending_steps.size() != 0 || i_valid || expected_times.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Mostly legal steps and sets, biased toward wrap edges and the target time
    task automatic queue_random_steps(int count);
        int n;
        int pick;
        logic [3:0] op;
        logic [7:0] h, m, s;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = 4'($urandom_range(OP_SUB_HOUR, OP_ADD_SEC));
            h = 8'($urandom_range(255));
            m = 8'($urandom_range(255));
            s = 8'($urandom_range(255));
            if (pick >= 55 && pick < 70) begin
                op = OP_SET;
                if (pick < 62) begin
                    h = $urandom_range(1) ? 8'(LAST_HOUR) : 8'd0;
                    m = $urandom_range(1) ? 8'(LAST_MINUTE) : 8'd0;
                    s = ($urandom_range(2) == 0) ? 8'd0 :
                        8'($urandom_range(LAST_SECOND, LAST_SECOND - 1));
                end else begin
                    h = 8'($urandom_range(LAST_HOUR));
                    m = 8'($urandom_range(LAST_MINUTE));
                    s = 8'($urandom_range(LAST_SECOND));
                end
            end else if (pick >= 70 && pick < 78) begin
                // land on or just short of the target time
                op = OP_SET;
                h = 8'(tgt_h);
                m = 8'(tgt_m);
                s = (tgt_s != 0) ? 8'(tgt_s - $urandom_range(1)) : 8'(tgt_s);
            end else if (pick >= 78 && pick < 88) begin
                op = OP_SET;
            end else if (pick >= 88) begin
                op = 4'($urandom_range(15));
            end
            push_step(op, h, m, s);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: wraps in every direction, set clamping, unused opcodes
        set_targets(6'd55, LAST_MINUTE, LAST_SECOND);
        push_step(OP_QUERY, 8'd0, 8'd0, 8'd0);
        push_step(OP_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF);
        push_step(OP_UNUSED_HI, 8'h55, 8'hAA, 8'h55);
        push_step(OP_SET, 8'd23, 8'd59, 8'd58);
        push_step(OP_ADD_SEC, 8'hAA, 8'h55, 8'hAA);
        push_step(OP_ADD_SEC, 8'd0, 8'd0, 8'd0);
        push_step(OP_SUB_SEC, 8'd0, 8'd0, 8'd0);
        push_step(OP_SET, 8'd255, 8'd255, 8'd255);
        push_step(OP_SET, 8'd24, 8'd60, 8'd60);
        push_step(OP_SET, 8'd23, 8'd59, 8'd59);
        push_step(OP_ADD_MIN, 8'd0, 8'd0, 8'd0);
        push_step(OP_SUB_MIN, 8'd0, 8'd0, 8'd0);
        push_step(OP_ADD_MIN_ONLY, 8'd0, 8'd0, 8'd0);
        push_step(OP_SUB_MIN_ONLY, 8'd0, 8'd0, 8'd0);
        push_step(OP_ADD_HOUR, 8'd0, 8'd0, 8'd0);
        push_step(OP_SUB_HOUR, 8'd0, 8'd0, 8'd0);
        push_step(OP_SET, 8'd0, 8'd0, 8'd0);
        push_step(OP_SUB_SEC, 8'd0, 8'd0, 8'd0);
        push_step(OP_SET, 8'd19, 8'd45, 8'd37);
        push_step(OP_SUB_SEC, 8'd0, 8'd0, 8'd0);
        push_step(OP_SET, 8'd10, 8'd10, 8'd10);
        push_step(OP_SUB_HOUR, 8'd0, 8'd0, 8'd0);
        wait_idle();

        // Target at midnight; hold the receiver off while steps keep coming
        set_targets(6'd0, 6'd0, 6'd0);
        rx_hold <= 1'b1;
        queue_random_steps(110);
        repeat (48) @(posedge i_clk);
        rx_hold <= 1'b0;
        wait_idle();

        // Sparse sender
        set_targets(6'd12, 6'd34, 6'd56);
        send_idle_pct <= 87;
        queue_random_steps(90);
        wait_idle();

        // Unreachable target; slow receiver
        set_targets(6'h3F, 6'h3F, 6'h3F);
        send_idle_pct <= 0;
        recv_stall_pct <= 87;
        queue_random_steps(90);
        wait_idle();

        // Both sides idle; sender drains fully midway
        set_targets(6'd23, 6'd0, 6'd59);
        send_idle_pct <= 31;
        recv_stall_pct <= 31;
        queue_random_steps(80);
        wait_idle();
        queue_random_steps(80);
        wait_idle();

        repeat (4) @(posedge i_clk);
        $display("ran %0d steps over five idle/target settings, %0d results checked",
                 accepted_steps, checked_results);
        $display("target matches seen %0d, last-second-of-day seen %0d, mismatches %0d",
                 target_hits, last_second_hits, mismatch_count);
        if (mismatch_count == 0 && expected_times.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/tod_pkg.sv
src/tod_step.sv
src/tod_fmt.sv
src/time_of_day_counter.sv
tb/tb_time_of_day_counter.sv
